// File: design/hsom_pkg.sv
// ----------------------------------------------------------------------------
// hsom_pkg: shared types and constants of the hit set overlap matcher
// Table geometry, counter widths, stream packing and the structs that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
package hsom_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_GROUPS  = 32;
    localparam int GROUP_W     = $clog2(MAX_GROUPS);
    localparam int NGRP_W      = $clog2(MAX_GROUPS + 1);
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 8;
    localparam int THR_W       = 4;
    localparam int PROD_W      = CNT_W + THR_W;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = (LEN_W > THR_W) ? LEN_W : THR_W;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(7);

    localparam int S_TDATA_W   = ((IDX_W + 2 * WORD_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;

    typedef enum logic {
        KIND_TABLE = 1'b0,
        KIND_HIT   = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH = 1'b0,
        CFG_THRESHOLD    = 1'b1
    } cfg_reg_t;

    // request into the table stage: a word write or a hit lookup
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_index;
        logic [WORD_W-1:0] wr_word;
        logic              hit_en;
        logic [WORD_W-1:0] hit_id;
    } cam_req_t;

    // control that travels beside the table stages
    typedef struct packed {
        logic vld;
        logic hit;
        logic region;
        logic last;
    } item_ctl_t;

    // result word, laid out as on m_tdata (lowest field last)
    typedef struct packed {
        logic [CNT_W-1:0]   matched_hits;
        logic [CNT_W-1:0]   region_hits;
        logic [GROUP_W-1:0] group;
        logic               accepted;
    } verdict_t;

    localparam int M_TDATA_W = (($bits(verdict_t) + 7) / 8) * 8;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: design/hit_set_overlap_matcher.sv
// ----------------------------------------------------------------------------
// hit_set_overlap_matcher: reference track overlap matcher
// Loads a zero-delimited table of reference hit ids, counts per group the
// region hits of a track found in that group and judges the track on its
// last hit.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    tdata, tuser {hit_in_region, kind}, tlast
//  m_       out  m_tvalid / m_tready    tdata {matched, region, group, accepted}
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle in while no result stalls the pipeline; after the last
// hit word m_tvalid rises once it has passed the input register, table
// compare, group fold, counter update and result register.
// Stalls: while a result waits on m_tready the whole pipeline holds and
// s_tready is low. Reset clears counters, length (0) and threshold (7); table
// contents are undefined until written.
// ----------------------------------------------------------------------------
module hit_set_overlap_matcher (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] table_index, [37:6] table_word, [69:38] hit_id, rest zero
    input  logic [hsom_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] kind, [1] hit_in_region
    input  logic [hsom_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] track_accepted, [5:1] matching_group, [13:6] region_hits,
    // [21:14] matched_hits, rest zero
    output logic [hsom_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsom_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsom_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsom_pkg::*;

    logic                en;

    logic [LEN_W-1:0]    len_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [LEN_W-1:0]    used_len;

    logic                s0_vld_reg;
    kind_t               s0_kind_reg;
    logic [IDX_W-1:0]    s0_index_reg;
    logic [WORD_W-1:0]   s0_word_reg;
    logic [WORD_W-1:0]   s0_id_reg;
    logic                s0_region_reg;
    logic                s0_last_reg;

    cam_req_t            cam_req;
    item_ctl_t           s0_ctl;
    item_ctl_t           a_ctl_reg;
    item_ctl_t           b_ctl_reg;
    logic [MAX_GROUPS-1:0] found;
    logic [NGRP_W-1:0]   n_groups;

    logic [CNT_W-1:0]    counts_reg [MAX_GROUPS];
    logic [CNT_W-1:0]    counts_next [MAX_GROUPS];
    logic [CNT_W-1:0]    hits_reg;
    logic [CNT_W-1:0]    hits_next;

    logic                c_vld_reg;
    logic [CNT_W-1:0]    snap_counts_reg [MAX_GROUPS];
    logic [CNT_W-1:0]    snap_hits_reg;
    logic [NGRP_W-1:0]   snap_ngrp_reg;

    verdict_t            verdict;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = aresetn && en;
    assign cfg_ready = aresetn;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign used_len = (len_reg > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_kind_reg   <= kind_t'(s_tuser[0]);
            s0_region_reg <= s_tuser[1];
            s0_last_reg   <= s_tlast;
            s0_index_reg  <= s_tdata[IDX_W-1:0];
            s0_word_reg   <= s_tdata[IDX_W +: WORD_W];
            s0_id_reg     <= s_tdata[IDX_W + WORD_W +: WORD_W];
        end
    end

    always_comb begin
        cam_req.wr_en    = s0_vld_reg && (s0_kind_reg == KIND_TABLE);
        cam_req.wr_index = s0_index_reg;
        cam_req.wr_word  = s0_word_reg;
        cam_req.hit_en   = s0_vld_reg && (s0_kind_reg == KIND_HIT) && s0_region_reg
                           && (s0_id_reg != '0);
        cam_req.hit_id   = s0_id_reg;
        s0_ctl.vld       = s0_vld_reg;
        s0_ctl.hit       = s0_vld_reg && (s0_kind_reg == KIND_HIT);
        s0_ctl.region    = s0_region_reg;
        s0_ctl.last      = s0_last_reg;
    end

    hsom_cam u_cam (
        .aclk     (aclk),
        .en       (en),
        .req      (cam_req),
        .used_len (used_len),
        .found    (found),
        .n_groups (n_groups)
    );

    // track counters with saturation
    always_comb begin
        hits_next = hits_reg;
        if (b_ctl_reg.hit && b_ctl_reg.region) begin
            hits_next = sat_inc(hits_reg);
        end
        for (int g = 0; g < MAX_GROUPS; g++) begin
            counts_next[g] = (b_ctl_reg.hit && found[g]) ? sat_inc(counts_reg[g])
                                                         : counts_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            thr_reg      <= THRESHOLD_RESET;
            s0_vld_reg   <= 1'b0;
            a_ctl_reg    <= '0;
            b_ctl_reg    <= '0;
            hits_reg     <= '0;
            c_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                counts_reg[g] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_TABLE_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                    CFG_THRESHOLD:    thr_reg <= cfg_data[THR_W-1:0];
                endcase
            end
            if (en) begin
                s0_vld_reg   <= s_tvalid;
                a_ctl_reg    <= s0_ctl;
                b_ctl_reg    <= a_ctl_reg;
                c_vld_reg    <= b_ctl_reg.hit && b_ctl_reg.last;
                m_tvalid_reg <= c_vld_reg;
                // drop the track counts once the last hit is snapped
                if (b_ctl_reg.hit && b_ctl_reg.last) begin
                    hits_reg <= '0;
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        counts_reg[g] <= '0;
                    end
                end else begin
                    hits_reg <= hits_next;
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        counts_reg[g] <= counts_next[g];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (b_ctl_reg.hit && b_ctl_reg.last) begin
                snap_hits_reg <= hits_next;
                snap_ngrp_reg <= n_groups;
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    snap_counts_reg[g] <= counts_next[g];
                end
            end
            m_tdata_reg <= M_TDATA_W'(verdict);
        end
    end

    hsom_judge u_judge (
        .counts    (snap_counts_reg),
        .hits      (snap_hits_reg),
        .n_groups  (snap_ngrp_reg),
        .threshold (thr_reg),
        .verdict   (verdict)
    );

endmodule

// File: design/hsom_cam.sv
// ----------------------------------------------------------------------------
// hsom_cam: reference table with parallel lookup
// Holds the reference words, compares a hit against all of them at once and
// folds the match vector into one flag per closed group over two stages.
// ----------------------------------------------------------------------------
module hsom_cam (
    input  logic                         aclk,
    input  logic                         en,
    input  hsom_pkg::cam_req_t           req,
    input  logic [hsom_pkg::LEN_W-1:0]   used_len,
    output logic [hsom_pkg::MAX_GROUPS-1:0] found,
    output logic [hsom_pkg::NGRP_W-1:0]  n_groups
);
    import hsom_pkg::*;

    logic [WORD_W-1:0]      table_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] zero_reg;

    logic [TABLE_DEPTH-1:0] len_mask;
    logic [TABLE_DEPTH-1:0] zeros;
    logic [LEN_W-1:0]       total;
    logic [LEN_W-1:0]       prefix [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit;

    logic [TABLE_DEPTH-1:0] hit_reg;
    logic [GROUP_W-1:0]     grp_reg [TABLE_DEPTH];
    logic [LEN_W-1:0]       total_reg;

    logic [MAX_GROUPS-1:0]  found_next;
    logic [MAX_GROUPS-1:0]  found_reg;
    logic [NGRP_W-1:0]      ngrp_reg;

    always_ff @(posedge aclk) begin
        if (en && req.wr_en) begin
            table_reg[req.wr_index] <= req.wr_word;
            zero_reg[req.wr_index]  <= (req.wr_word == '0);
        end
    end

    // group of a word = closing zeros in use ahead of it
    always_comb begin
        logic [TABLE_DEPTH-1:0] below;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            len_mask[i] = (LEN_W'(i) < used_len);
        end
        zeros = zero_reg & len_mask;
        total = LEN_W'($countones(zeros));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            below     = (TABLE_DEPTH'(1) << i) - TABLE_DEPTH'(1);
            prefix[i] = LEN_W'($countones(zeros & below));
            hit[i]    = req.hit_en && len_mask[i] && (table_reg[i] == req.hit_id)
                        && (prefix[i] < total) && (prefix[i] < LEN_W'(MAX_GROUPS));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit;
            total_reg <= total;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                grp_reg[i] <= prefix[i][GROUP_W-1:0];
            end
        end
    end

    always_comb begin
        found_next = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (hit_reg[i] && (grp_reg[i] == GROUP_W'(g))) begin
                    found_next[g] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            found_reg <= found_next;
            ngrp_reg  <= (total_reg > LEN_W'(MAX_GROUPS)) ? NGRP_W'(MAX_GROUPS)
                                                          : total_reg[NGRP_W-1:0];
        end
    end

    assign found    = found_reg;
    assign n_groups = ngrp_reg;

endmodule

// File: design/hsom_judge.sv
// ----------------------------------------------------------------------------
// hsom_judge: track decision
// Tests every closed group against the match fraction and picks the first
// group that passes.
// ----------------------------------------------------------------------------
module hsom_judge (
    input  logic [hsom_pkg::CNT_W-1:0]  counts [hsom_pkg::MAX_GROUPS],
    input  logic [hsom_pkg::CNT_W-1:0]  hits,
    input  logic [hsom_pkg::NGRP_W-1:0] n_groups,
    input  logic [hsom_pkg::THR_W-1:0]  threshold,
    output hsom_pkg::verdict_t          verdict
);
    import hsom_pkg::*;

    logic [PROD_W-1:0] need;
    logic [PROD_W-1:0] score;

    assign need = PROD_W'(hits) * PROD_W'(threshold);

    // walk down so the lowest passing group wins
    always_comb begin
        verdict              = '0;
        verdict.region_hits  = hits;
        score                = '0;
        for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
            score = (PROD_W'(counts[g]) << 3) + (PROD_W'(counts[g]) << 1);
            if ((NGRP_W'(g) < n_groups) && (hits != '0) && (score > need)) begin
                verdict.accepted     = 1'b1;
                verdict.group        = GROUP_W'(g);
                verdict.matched_hits = counts[g];
            end
        end
    end

endmodule

// File: design/hsom_checker.sv
// ----------------------------------------------------------------------------
// hsom_checker: port level checks of the overlap matcher
// Watches the result stream and the input ready over time.
// ----------------------------------------------------------------------------
module hsom_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hsom_pkg::M_TDATA_W-1:0] m_tdata
);
    import hsom_pkg::*;

    verdict_t v;

    assign v = verdict_t'(m_tdata[$bits(verdict_t)-1:0]);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    a_matched_le_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> v.matched_hits <= v.region_hits)
        else $error("matched hits exceed region hits");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !v.accepted |-> v.group == '0 && v.matched_hits == '0)
        else $error("rejected track reports a group");

    a_accept_has_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && v.accepted |-> v.region_hits != '0 && v.matched_hits != '0)
        else $error("accepted track without region hits");

endmodule

bind hit_set_overlap_matcher hsom_checker u_hsom_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
